FILE: hdl/assert_macros.svh
// Assertion macros for the top RTL file of the FDTD step block.
// No dependencies; ASSERT_OFF turns every check into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/fst_pkg.sv
// Package of the FDTD step block: widths, codes, config struct, state types.
// No dependencies.
package fst_pkg;

   // Field value width (Q4.12)
   localparam int VALUE_W     = 16;
   localparam int BETA_W      = 16;
   localparam int POINTS_W    = 9;
   localparam int INDEX_W     = 8;
   localparam int MODE_W      = 2;
   localparam int GRID_POINTS = 256;

   // Fraction bits dropped from the Q.26 product by the rounding shift
   localparam int FRAC_SHIFT  = 14;

   // Three-point mean: floor((s + 1) / 3) via bias and reciprocal multiply
   localparam int SUM_W       = VALUE_W + 2;
   localparam int DIV_SHIFT   = VALUE_W + 3;
   localparam int DIV_BIAS    = 3 * (2 ** (VALUE_W - 1));
   localparam int DIV_RECIP   = ((2 ** DIV_SHIFT) + 2) / 3;

   // Request codes
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_STEP  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

   // Register map
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_BETA     = 2'd0;
   localparam logic [1:0] REG_BOUNDARY = 2'd1;
   localparam logic [1:0] REG_POINTS   = 2'd2;

   localparam logic [BETA_W-1:0]   BETA_RESET   = 16'd8192;
   localparam logic [POINTS_W-1:0] POINTS_RESET = 9'd256;

   typedef struct packed {
      logic signed [BETA_W-1:0] beta;
      logic                     absorbing;
      logic [POINTS_W-1:0]      points;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_STEP,
      ST_DRAIN
   } state_type;

   // Kind of a sweep slot entering the read stage
   typedef enum logic [1:0] {
      TOK_PRE,
      TOK_DATA,
      TOK_FINAL
   } tok_type;

endpackage

FILE: hdl/fst_ifs.sv
// Request and result channel interfaces of the FDTD step block.
// Depends on fst_pkg for field widths.
interface fst_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [fst_pkg::MODE_W-1:0]            mode;
   logic [fst_pkg::INDEX_W-1:0]           point_index;
   logic signed [fst_pkg::VALUE_W-1:0]    e_in;
   logic signed [fst_pkg::VALUE_W-1:0]    h_in;

   modport source (output valid, mode, point_index, e_in, h_in, input ready);
   modport sink   (input valid, mode, point_index, e_in, h_in, output ready);
endinterface

interface fst_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [fst_pkg::VALUE_W-1:0]    e_out;
   logic signed [fst_pkg::VALUE_W-1:0]    h_out;
   logic                                  saturated;

   modport source (output valid, e_out, h_out, saturated, input ready);
   modport sink   (input valid, e_out, h_out, saturated, output ready);
endinterface

FILE: hdl/fst_mem.sv
// Single field store: one write port, one read port, registered read data.
// No package dependencies.
module fst_mem #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port, data holds while re is low
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/fst_csr.sv
// APB-style configuration registers: beta, boundary mode, points in use.
// Depends on fst_pkg for the register map and cfg_type.
module fst_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fst_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fst_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fst_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output fst_pkg::cfg_type                 cfg
);

   fst_pkg::cfg_type cfg_ff;
   logic             wr_en;
   logic [1:0]       reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[3:2];

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.beta      <= fst_pkg::BETA_RESET;
         cfg_ff.absorbing <= 1'b0;
         cfg_ff.points    <= fst_pkg::POINTS_RESET;
      end else if (wr_en) begin
         case (reg_sel)
            fst_pkg::REG_BETA:     cfg_ff.beta      <= pwdata[fst_pkg::BETA_W-1:0];
            fst_pkg::REG_BOUNDARY: cfg_ff.absorbing <= pwdata[0];
            fst_pkg::REG_POINTS:   cfg_ff.points    <= pwdata[fst_pkg::POINTS_W-1:0];
            default: ;
         endcase
      end
   end

   // Read-back
   always_comb begin
      case (reg_sel)
         fst_pkg::REG_BETA:
            prdata = fst_pkg::CSR_DATA_W'(cfg_ff.beta);
         fst_pkg::REG_BOUNDARY:
            prdata = fst_pkg::CSR_DATA_W'(cfg_ff.absorbing);
         fst_pkg::REG_POINTS:
            prdata = fst_pkg::CSR_DATA_W'(cfg_ff.points);
         default:
            prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/fst_update.sv
// One field update: registered beta*(left-right) product, then round,
// add, saturate. Depends on fst_pkg for widths.
module fst_update (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [fst_pkg::BETA_W-1:0]   beta,
   input  logic signed [fst_pkg::VALUE_W-1:0]  center,
   input  logic signed [fst_pkg::VALUE_W-1:0]  left,
   input  logic signed [fst_pkg::VALUE_W-1:0]  right,
   input  logic                                zero_end,
   output logic signed [fst_pkg::VALUE_W-1:0]  new_val,
   output logic                                sat_hit
);

   localparam int VW = fst_pkg::VALUE_W;
   localparam int DW = VW + 1;
   localparam int PW = fst_pkg::BETA_W + DW;
   localparam int RW = PW + 1;
   localparam int IW = RW - fst_pkg::FRAC_SHIFT;
   localparam int SW = IW + 1;
   localparam logic signed [SW-1:0] VMAX = SW'((2 ** (VW - 1)) - 1);
   localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);

   logic signed [DW-1:0] diff;
   logic signed [PW-1:0] prod_in;
   logic signed [PW-1:0] prod_ff;
   logic signed [VW-1:0] old_ff;
   logic                 zero_ff;
   logic signed [RW-1:0] rnd;
   logic signed [IW-1:0] inc;
   logic signed [SW-1:0] sum;

   assign diff    = DW'(left) - DW'(right);
   assign prod_in = PW'(beta) * PW'(diff);

   // Product stage
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         old_ff  <= center;
         zero_ff <= zero_end;
      end
   end

   // Round to nearest (ties up), add, saturate; absorbing ends read zero
   always_comb begin
      rnd = RW'(prod_ff) + RW'(2 ** (fst_pkg::FRAC_SHIFT - 1));
      inc = rnd[RW-1:fst_pkg::FRAC_SHIFT];
      sum = SW'(old_ff) + SW'(inc);
      if (zero_ff) begin
         new_val = '0;
         sat_hit = 1'b0;
      end else if (sum > VMAX) begin
         new_val = VMAX[VW-1:0];
         sat_hit = 1'b1;
      end else if (sum < VMIN) begin
         new_val = VMIN[VW-1:0];
         sat_hit = 1'b1;
      end else begin
         new_val = sum[VW-1:0];
         sat_hit = 1'b0;
      end
   end

endmodule

FILE: hdl/fdtd_1d_smoothed_step.sv
// FDTD 1-D step block. Write request: stored as it is accepted. Read request:
// result through the memory read register and the result register, next
// request taken while the result waits. Time step: a wrap fetch of the last
// point, one read per point, a final slot, then a drain, using one read and
// one write per memory port per cycle. Reset (synchronous) runs a clearing
// pass through both field memories; requests wait, config writes are taken.
`include "assert_macros.svh"

module fdtd_1d_smoothed_step #(
   parameter int GRID_POINTS = fst_pkg::GRID_POINTS
) (
   input  logic                            clock,
   input  logic                            reset,
   fst_req_if.sink                         req_ch,
   fst_rsp_if.source                       rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [fst_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [fst_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [fst_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);

   localparam int VW = fst_pkg::VALUE_W;
   localparam int AW = $clog2(GRID_POINTS);
   localparam int CW = (AW + 1 > fst_pkg::POINTS_W) ? AW + 1 : fst_pkg::POINTS_W;
   localparam int SW = fst_pkg::SUM_W;

   // Three-point mean, floor((a + b + c + 1) / 3)
   function automatic logic signed [VW-1:0] mean3(
      input logic signed [VW-1:0] a,
      input logic signed [VW-1:0] b,
      input logic signed [VW-1:0] c
   );
      logic signed [SW-1:0] s;
      logic [SW-1:0]        u;
      logic [2*SW-1:0]      p;
      logic [VW-1:0]        q;
      s = SW'(a) + SW'(b) + SW'(c) + SW'(1);
      u = SW'(s) + SW'(fst_pkg::DIV_BIAS);
      p = (2*SW)'(u) * (2*SW)'(fst_pkg::DIV_RECIP);
      q = p[fst_pkg::DIV_SHIFT +: VW];
      mean3 = {~q[VW-1], q[VW-2:0]};
   endfunction

   fst_pkg::cfg_type   cfg;
   fst_pkg::state_type state_ff, state_in;

   // Memory ports
   logic                 mem_we, mem_re;
   logic [AW-1:0]        mem_waddr, mem_raddr;
   logic signed [VW-1:0] wdata_e, wdata_h, rd_e, rd_h;

   // Sweep control
   logic [AW-1:0]        clr_ff;
   logic [CW-1:0]        iss_ff, iss_in;
   logic [CW-1:0]        n_cnt, piu;
   logic [AW-1:0]        last_addr;
   logic                 req_acc, idx_ok;
   logic [AW-1:0]        idx_addr;

   // Read stage
   logic                 r_v_ff, r_v_in;
   fst_pkg::tok_type     r_kind_ff, r_kind_in;
   logic [AW-1:0]        r_k_ff, r_k_in;
   logic signed [VW-1:0] oa_e_ff, ob_e_ff, oa_h_ff, ob_h_ff;
   logic signed [VW-1:0] head_e_ff, head_h_ff, tail_e_ff, tail_h_ff;
   logic                 launch, first_pt, is_end;
   logic [AW-1:0]        c_addr;
   logic signed [VW-1:0] le, re_v, lh, rh;

   // Update and window stages
   logic                 p_v_ff;
   logic [AW-1:0]        p_c_ff;
   logic signed [VW-1:0] new_e, new_h;
   logic                 hit_e, hit_h;
   logic                 w_v_ff;
   logic [AW-1:0]        w_m_ff;
   logic signed [VW-1:0] na_e_ff, nb_e_ff, nc_e_ff, na_h_ff, nb_h_ff, nc_h_ff;
   logic                 last_pend_ff, last_pend_in;
   logic                 pipe_we;
   logic [AW-1:0]        pipe_waddr;
   logic signed [VW-1:0] pipe_e, pipe_h;

   // Flag and result
   logic                 flag_ff;
   logic                 sat_pend_ff, oob_ff;
   logic                 rsp_v_ff;
   logic signed [VW-1:0] rsp_e_ff, rsp_h_ff;
   logic                 rsp_sat_ff;
   logic                 slot_free;

   // Assertion helpers
   logic                 step_rw, pipe_busy, in_read;

   fst_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fst_mem #(.DEPTH(GRID_POINTS), .WIDTH(VW)) u_mem_e (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (wdata_e),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (rd_e)
   );

   fst_mem #(.DEPTH(GRID_POINTS), .WIDTH(VW)) u_mem_h (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (wdata_h),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (rd_h)
   );

   // Effective point count, clamped to [3, GRID_POINTS]
   assign piu = CW'(cfg.points);
   always_comb begin
      if (piu < CW'(3)) begin
         n_cnt = CW'(3);
      end else if (piu > CW'(GRID_POINTS)) begin
         n_cnt = CW'(GRID_POINTS);
      end else begin
         n_cnt = piu;
      end
   end
   assign last_addr = AW'(n_cnt - CW'(1));

   assign req_acc  = req_ch.valid && req_ch.ready;
   assign idx_ok   = CW'(req_ch.point_index) < CW'(GRID_POINTS);
   assign idx_addr = AW'(req_ch.point_index);
   assign slot_free = !rsp_v_ff || rsp_ch.ready;

   // Write-back from the window: end points raw, interior smoothed
   always_comb begin
      pipe_we      = 1'b0;
      pipe_waddr   = '0;
      pipe_e       = na_e_ff;
      pipe_h       = na_h_ff;
      last_pend_in = w_v_ff && (w_m_ff == last_addr);
      if (last_pend_ff) begin
         pipe_we    = 1'b1;
         pipe_waddr = last_addr;
      end else if (w_v_ff) begin
         if (w_m_ff == '0) begin
            pipe_we = 1'b1;
         end else if (w_m_ff != AW'(1)) begin
            pipe_we    = 1'b1;
            pipe_waddr = w_m_ff - AW'(1);
            pipe_e     = mean3(nc_e_ff, nb_e_ff, na_e_ff);
            pipe_h     = mean3(nc_h_ff, nb_h_ff, na_h_ff);
         end
      end
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fst_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state, memory port muxing, sweep issue
   always_comb begin
      state_in     = state_ff;
      req_ch.ready = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      wdata_e      = '0;
      wdata_h      = '0;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      iss_in       = iss_ff;
      r_v_in       = 1'b0;
      r_kind_in    = fst_pkg::TOK_DATA;
      r_k_in       = '0;
      case (state_ff)
         fst_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            if (clr_ff == AW'(GRID_POINTS - 1)) begin
               state_in = fst_pkg::ST_IDLE;
            end
         end
         fst_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_acc) begin
               case (req_ch.mode)
                  fst_pkg::MODE_WRITE: begin
                     mem_we    = idx_ok;
                     mem_waddr = idx_addr;
                     wdata_e   = req_ch.e_in;
                     wdata_h   = req_ch.h_in;
                  end
                  fst_pkg::MODE_STEP: begin
                     state_in = fst_pkg::ST_STEP;
                     iss_in   = '0;
                  end
                  fst_pkg::MODE_READ: begin
                     mem_re    = 1'b1;
                     mem_raddr = idx_addr;
                     state_in  = fst_pkg::ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         fst_pkg::ST_READ: begin
            if (slot_free) begin
               state_in = fst_pkg::ST_IDLE;
            end
         end
         fst_pkg::ST_STEP: begin
            mem_we    = pipe_we;
            mem_waddr = pipe_waddr;
            wdata_e   = pipe_e;
            wdata_h   = pipe_h;
            iss_in    = iss_ff + CW'(1);
            r_v_in    = 1'b1;
            if (iss_ff == '0) begin
               // Fetch the last point first for the wrap at point 0
               mem_re    = 1'b1;
               mem_raddr = last_addr;
               r_kind_in = fst_pkg::TOK_PRE;
            end else if (iss_ff <= n_cnt) begin
               mem_re    = 1'b1;
               mem_raddr = AW'(iss_ff - CW'(1));
               r_k_in    = AW'(iss_ff - CW'(1));
            end else begin
               r_kind_in = fst_pkg::TOK_FINAL;
               state_in  = fst_pkg::ST_DRAIN;
            end
         end
         fst_pkg::ST_DRAIN: begin
            mem_we    = pipe_we;
            mem_waddr = pipe_waddr;
            wdata_e   = pipe_e;
            wdata_h   = pipe_h;
            if (!r_v_ff && !p_v_ff && !w_v_ff && !last_pend_ff) begin
               state_in = fst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fst_pkg::ST_IDLE;
         end
      endcase
   end

   // Clear counter and sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         iss_ff <= '0;
      end else begin
         iss_ff <= iss_in;
         if (state_ff == fst_pkg::ST_CLEAR) begin
            clr_ff <= clr_ff + AW'(1);
         end
      end
   end

   // Read stage: operand selection for the point behind the read pointer
   assign first_pt = (r_kind_ff == fst_pkg::TOK_DATA) && (r_k_ff == AW'(1));
   assign launch   = r_v_ff && ((r_kind_ff == fst_pkg::TOK_FINAL) ||
                     ((r_kind_ff == fst_pkg::TOK_DATA) && (r_k_ff != '0)));
   assign c_addr   = (r_kind_ff == fst_pkg::TOK_FINAL) ? last_addr : r_k_ff - AW'(1);
   assign is_end   = (c_addr == '0) || (c_addr == last_addr);
   assign lh       = first_pt ? tail_h_ff : ob_h_ff;
   assign le       = first_pt ? tail_e_ff : ob_e_ff;
   assign rh       = (r_kind_ff == fst_pkg::TOK_FINAL) ? head_h_ff : rd_h;
   assign re_v     = (r_kind_ff == fst_pkg::TOK_FINAL) ? head_e_ff : rd_e;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_v_ff <= 1'b0;
         p_v_ff <= 1'b0;
         w_v_ff <= 1'b0;
         last_pend_ff <= 1'b0;
      end else begin
         r_v_ff <= r_v_in;
         p_v_ff <= launch;
         w_v_ff <= p_v_ff;
         last_pend_ff <= last_pend_in;
      end
   end

   // Old-value window and wrap registers
   always_ff @(posedge clock) begin
      r_kind_ff <= r_kind_in;
      r_k_ff    <= r_k_in;
      p_c_ff    <= c_addr;
      if (r_v_ff && r_kind_ff == fst_pkg::TOK_PRE) begin
         tail_e_ff <= rd_e;
         tail_h_ff <= rd_h;
      end
      if (r_v_ff && r_kind_ff == fst_pkg::TOK_DATA) begin
         oa_e_ff <= rd_e;
         ob_e_ff <= oa_e_ff;
         oa_h_ff <= rd_h;
         ob_h_ff <= oa_h_ff;
         if (r_k_ff == '0) begin
            head_e_ff <= rd_e;
            head_h_ff <= rd_h;
         end
      end
   end

   // E uses H neighbors, H uses E neighbors
   fst_update u_upd_e (
      .clock    (clock),
      .en       (launch),
      .beta     (cfg.beta),
      .center   (oa_e_ff),
      .left     (lh),
      .right    (rh),
      .zero_end (is_end && cfg.absorbing),
      .new_val  (new_e),
      .sat_hit  (hit_e)
   );

   fst_update u_upd_h (
      .clock    (clock),
      .en       (launch),
      .beta     (cfg.beta),
      .center   (oa_h_ff),
      .left     (le),
      .right    (re_v),
      .zero_end (is_end && cfg.absorbing),
      .new_val  (new_h),
      .sat_hit  (hit_h)
   );

   // New-value window for smoothing
   always_ff @(posedge clock) begin
      if (p_v_ff) begin
         na_e_ff <= new_e;
         nb_e_ff <= na_e_ff;
         nc_e_ff <= nb_e_ff;
         na_h_ff <= new_h;
         nb_h_ff <= na_h_ff;
         nc_h_ff <= nb_h_ff;
         w_m_ff  <= p_c_ff;
      end
   end

   // Saturation flag: set by a step, handed out and cleared by a read
   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
      end else if (req_acc && req_ch.mode == fst_pkg::MODE_READ) begin
         flag_ff <= 1'b0;
      end else if (p_v_ff && (hit_e || hit_h)) begin
         flag_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc && req_ch.mode == fst_pkg::MODE_READ) begin
         sat_pend_ff <= flag_ff;
         oob_ff      <= !idx_ok;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (state_ff == fst_pkg::ST_READ && slot_free) begin
         rsp_v_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == fst_pkg::ST_READ && slot_free) begin
         rsp_e_ff   <= oob_ff ? '0 : rd_e;
         rsp_h_ff   <= oob_ff ? '0 : rd_h;
         rsp_sat_ff <= sat_pend_ff;
      end
   end

   assign rsp_ch.valid     = rsp_v_ff;
   assign rsp_ch.e_out     = rsp_e_ff;
   assign rsp_ch.h_out     = rsp_h_ff;
   assign rsp_ch.saturated = rsp_sat_ff;

   assign step_rw   = (state_ff == fst_pkg::ST_STEP) && mem_we && mem_re;
   assign pipe_busy = r_v_ff || p_v_ff || w_v_ff || last_pend_ff;
   assign in_read   = (state_ff == fst_pkg::ST_READ);

   // Write-back never lands on the entry being fetched in the same cycle
   `ASSERT_IMPLIES(a_no_rw_clash, clock, reset, step_rw, mem_waddr != mem_raddr)
   // A new result only comes out of a memory read
   `ASSERT_IMPLIES(a_rsp_from_read, clock, reset, $rose(rsp_v_ff), $past(in_read))
   // Sweep pipeline is empty whenever requests are taken
   `ASSERT_ALWAYS(a_idle_empty, clock, reset, (state_ff != fst_pkg::ST_IDLE) || !pipe_busy)

endmodule
